// ----- rtl/core/kctc_pkg.sv -----
// Package for the keypad countdown timer control block.
// Holds the word and state types, key and tone codes and time limits.
// No dependencies; used by every module of the block.
package kctc_pkg;

	// Time limits and the long-press step
	localparam logic [6:0] MAX_MINUTES = 7'd99;
	localparam logic [5:0] MAX_SECONDS = 6'd59;
	localparam logic [2:0] LONG_STEP   = 3'd3;

	// Key codes
	localparam logic [2:0] KEY_POWER   = 3'd1;
	localparam logic [2:0] KEY_MINUTES = 3'd2;
	localparam logic [2:0] KEY_SECONDS = 3'd3;
	localparam logic [2:0] KEY_START   = 3'd4;

	// Word kinds
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Buzzer tones
	localparam logic [2:0] TONE_NONE      = 3'd0;
	localparam logic [2:0] TONE_POWER_OFF = 3'd1;
	localparam logic [2:0] TONE_POWER_ON  = 3'd2;
	localparam logic [2:0] TONE_ALARM     = 3'd3;
	localparam logic [2:0] TONE_CLICK     = 3'd4;

	// Input word
	typedef struct packed {
		logic       kind;
		logic [2:0] key_code;
		logic       long_press;
	} item_t;

	// Controller state
	typedef struct packed {
		logic       power;
		logic       run;
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic [2:0] tone;
	} state_t;

	// Pulses produced with a word
	typedef struct packed {
		logic tone_start;
		logic port_clear;
	} pulse_t;

	// Result word
	typedef struct packed {
		logic       power_on;
		logic       running;
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic [2:0] tone_select;
		logic       tone_start;
		logic       port_clear;
	} result_t;

endpackage

// ----- rtl/core/kctc_item_if.sv -----
// Valid/ready channel carrying key and tick words into the timer control.
// Depends on nothing but plain logic fields.
interface kctc_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] key_code;
	logic       long_press;

	modport source (output valid, output kind, output key_code, output long_press,
		input ready);
	modport sink (input valid, input kind, input key_code, input long_press,
		output ready);
endinterface

// ----- rtl/core/kctc_result_if.sv -----
// Valid/ready channel carrying result words out of the timer control.
// Depends on nothing but plain logic fields.
interface kctc_result_if;
	logic       valid;
	logic       ready;
	logic       power_on;
	logic       running;
	logic [6:0] minutes;
	logic [5:0] seconds;
	logic [2:0] tone_select;
	logic       tone_start;
	logic       port_clear;

	modport source (output valid, output power_on, output running, output minutes,
		output seconds, output tone_select, output tone_start, output port_clear,
		input ready);
	modport sink (input valid, input power_on, input running, input minutes,
		input seconds, input tone_select, input tone_start, input port_clear,
		output ready);
endinterface

// ----- rtl/core/keypad_countdown_timer_control.sv -----
// Top level of the keypad countdown timer control.
// Depends on kctc_pkg, kctc_item_if, kctc_result_if and kctc_step.
//
// Usage: key and tick words arrive on the item channel (valid/ready);
// each accepted word gives exactly one result word on the result channel,
// holding the power and run flags, the time, the chosen tone and the
// tone_start and port_clear pulses.
// The word is captured in an input register; the step logic then loads the
// state and the result register, which holds the result offered on the result channel.
// Throughput is one word per cycle: the input register, state and result
// register all move together whenever the result register is empty or is
// being taken, so ready stays high while results keep flowing.
// When the receiver stalls, the result register holds, then the input
// register fills, and item ready drops until the result is taken.
// Reset clears both valid flags and the state: powered off, not running,
// 00:00, no tone.
module keypad_countdown_timer_control
	import kctc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	kctc_item_if.sink            item,
	kctc_result_if.source        result
);

	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	pulse_t  pulse;
	logic    advance;

	// Pipeline moves when the result register is free or being taken
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{kind: item.kind, key_code: item.key_code,
				long_press: item.long_press};
		end
	end

	kctc_step u_step (
		.cur   (state_q),
		.item  (item_s1),
		.nxt   (state_nxt),
		.pulse (pulse)
	);

	// Controller state, updated as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{power: 1'b0, run: 1'b0, minutes: '0, seconds: '0,
				tone: TONE_NONE};
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= '{power_on: state_nxt.power, running: state_nxt.run,
				minutes: state_nxt.minutes, seconds: state_nxt.seconds,
				tone_select: state_nxt.tone, tone_start: pulse.tone_start,
				port_clear: pulse.port_clear};
		end
	end

	assign result.valid       = valid_s2;
	assign result.power_on    = result_s2.power_on;
	assign result.running     = result_s2.running;
	assign result.minutes     = result_s2.minutes;
	assign result.seconds     = result_s2.seconds;
	assign result.tone_select = result_s2.tone_select;
	assign result.tone_start  = result_s2.tone_start;
	assign result.port_clear  = result_s2.port_clear;

`ifndef SYNTHESIS
	// time never leaves 00:00 .. 99:59
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.minutes <= MAX_MINUTES && state_q.seconds <= MAX_SECONDS)
		else $error("time out of range");

	// countdown only runs while powered
	a_run_needs_power: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.run |-> state_q.power)
		else $error("running while powered off");

	// port clear only comes with a power-off result
	a_port_clear_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.port_clear |-> !result_s2.power_on && result_s2.tone_start)
		else $error("port clear without power off");

	// state holds while the pipeline is stalled
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed during stall");
`endif

endmodule

// ----- rtl/core/kctc_step.sv -----
// Next-state logic of the timer control: applies one key or tick word.
// Depends on kctc_pkg for the word, state and pulse types and the codes.
module kctc_step
	import kctc_pkg::*;
(
	input  state_t cur,
	input  item_t  item,
	output state_t nxt,
	output pulse_t pulse
);

	logic [6:0] min_sum;
	logic [6:0] sec_sum;
	logic       min_room;

	// Sums for the set keys; neither can overflow its width
	assign min_sum  = cur.minutes + {4'd0, LONG_STEP};
	assign sec_sum  = {1'b0, cur.seconds} + (item.long_press ? {4'd0, LONG_STEP} : 7'd1);
	assign min_room = (cur.minutes < MAX_MINUTES);

	always_comb begin
		nxt   = cur;
		pulse = '0;
		if (item.kind == KIND_KEY) begin
			case (item.key_code)
				KEY_POWER: begin
					if (!cur.power) begin
						nxt.power   = 1'b1;
						nxt.minutes = '0;
						nxt.seconds = '0;
						nxt.tone    = TONE_POWER_ON;
					end else begin
						nxt.power        = 1'b0;
						nxt.tone         = TONE_POWER_OFF;
						pulse.port_clear = 1'b1;
					end
					nxt.run          = 1'b0;
					pulse.tone_start = 1'b1;
				end
				KEY_MINUTES: begin
					if (cur.power && !cur.run && min_room) begin
						if (!item.long_press) begin
							nxt.minutes = cur.minutes + 7'd1;
						end else if (min_sum > MAX_MINUTES) begin
							nxt.minutes = MAX_MINUTES;
							nxt.seconds = MAX_SECONDS;
						end else begin
							nxt.minutes = min_sum;
						end
					end
				end
				KEY_SECONDS: begin
					if (cur.power && !cur.run) begin
						if (sec_sum <= {1'b0, MAX_SECONDS}) begin
							nxt.seconds = sec_sum[5:0];
						end else if (min_room) begin
							// wrap with carry into the minutes
							nxt.minutes = cur.minutes + 7'd1;
							nxt.seconds = 6'(sec_sum - 7'd60);
						end else if (item.long_press) begin
							nxt.minutes = MAX_MINUTES;
							nxt.seconds = MAX_SECONDS;
						end
					end
				end
				KEY_START: begin
					if (cur.power) begin
						if (cur.run) begin
							nxt.run     = 1'b0;
							nxt.minutes = '0;
							nxt.seconds = '0;
						end else if (cur.minutes != '0 || cur.seconds != '0) begin
							nxt.run = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			// key click for the set and start keys while powered
			if (cur.power && (item.key_code inside {KEY_MINUTES, KEY_SECONDS, KEY_START})) begin
				nxt.tone         = TONE_CLICK;
				pulse.tone_start = 1'b1;
			end
		end else if (cur.power && cur.run) begin
			// countdown tick; at zero the alarm restarts every second
			if (cur.seconds != '0) begin
				nxt.seconds = cur.seconds - 6'd1;
			end else if (cur.minutes != '0) begin
				nxt.minutes = cur.minutes - 7'd1;
				nxt.seconds = MAX_SECONDS;
			end else begin
				nxt.tone         = TONE_ALARM;
				pulse.tone_start = 1'b1;
			end
		end
	end

endmodule

// ----- sim/kctc_timer_checker.sv -----
// Result checker for the keypad countdown timer control testbench.
// Tracks the timer state from accepted key and tick words and compares each result word.
// Depends on kctc_pkg for the word, state and code definitions.
module kctc_timer_checker
	import kctc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item_word,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result_word,
	output int      mismatches,
	output int      waiting,
	output int      checked,
	output int      alarms
);
	timeunit 1ns;
	timeprecision 1ps;

	state_t  timer_model;
	result_t expected_words[$];

	// Clamp the time to its ceiling
	function automatic void set_full_time();
		timer_model.minutes = MAX_MINUTES;
		timer_model.seconds = MAX_SECONDS;
	endfunction

	// Apply one word to the timer state and build the result it gives
	function automatic result_t apply_word(input item_t w);
		result_t    r;
		logic [7:0] min_sum;
		logic [6:0] sec_sum;
		r = '0;
		if (w.kind == KIND_KEY) begin
			case (w.key_code)
				KEY_POWER: begin
					if (!timer_model.power) begin
						timer_model.power   = 1'b1;
						timer_model.minutes = '0;
						timer_model.seconds = '0;
						timer_model.tone    = TONE_POWER_ON;
					end else begin
						timer_model.power = 1'b0;
						timer_model.tone  = TONE_POWER_OFF;
						r.port_clear      = 1'b1;
					end
					timer_model.run = 1'b0;
					r.tone_start    = 1'b1;
				end
				KEY_MINUTES: begin
					if (timer_model.power && !timer_model.run
							&& timer_model.minutes < MAX_MINUTES) begin
						if (!w.long_press) begin
							timer_model.minutes = timer_model.minutes + 7'd1;
						end else begin
							min_sum = {1'b0, timer_model.minutes} + LONG_STEP;
							if (min_sum > MAX_MINUTES)
								set_full_time();
							else
								timer_model.minutes = min_sum[6:0];
						end
					end
				end
				KEY_SECONDS: begin
					if (timer_model.power && !timer_model.run) begin
						sec_sum = {1'b0, timer_model.seconds}
							+ (w.long_press ? 7'(LONG_STEP) : 7'd1);
						if (sec_sum <= MAX_SECONDS) begin
							timer_model.seconds = sec_sum[5:0];
						end else if (timer_model.minutes < MAX_MINUTES) begin
							// wrap into the next minute
							timer_model.minutes = timer_model.minutes + 7'd1;
							timer_model.seconds = 6'(sec_sum - (MAX_SECONDS + 7'd1));
						end else if (w.long_press) begin
							set_full_time();
						end
					end
				end
				KEY_START: begin
					if (timer_model.power) begin
						if (timer_model.run) begin
							timer_model.run     = 1'b0;
							timer_model.minutes = '0;
							timer_model.seconds = '0;
						end else if (timer_model.minutes != 0 || timer_model.seconds != 0) begin
							timer_model.run = 1'b1;
						end
					end
				end
				default: ;
			endcase
			// any setting key clicks while powered
			if (timer_model.power && (w.key_code == KEY_MINUTES
					|| w.key_code == KEY_SECONDS || w.key_code == KEY_START)) begin
				timer_model.tone = TONE_CLICK;
				r.tone_start     = 1'b1;
			end
		end else if (timer_model.power && timer_model.run) begin
			// countdown; alarm on every tick once at zero
			if (timer_model.seconds != 0) begin
				timer_model.seconds = timer_model.seconds - 6'd1;
			end else if (timer_model.minutes != 0) begin
				timer_model.minutes = timer_model.minutes - 7'd1;
				timer_model.seconds = MAX_SECONDS;
			end else begin
				timer_model.tone = TONE_ALARM;
				r.tone_start     = 1'b1;
			end
		end
		r.power_on    = timer_model.power;
		r.running     = timer_model.run;
		r.minutes     = timer_model.minutes;
		r.seconds     = timer_model.seconds;
		r.tone_select = timer_model.tone;
		return r;
	endfunction

	// Predict on accepted words, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			timer_model = '0;
			expected_words.delete();
			mismatches <= 0;
			waiting    <= 0;
			checked    <= 0;
			alarms     <= 0;
		end else begin
			if (item_valid && item_ready)
				expected_words.push_back(apply_word(item_word));
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word with nothing expected", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_words.pop_front();
					checked <= checked + 1;
					if (result_word.tone_start === 1'b1 && result_word.tone_select === TONE_ALARM)
						alarms <= alarms + 1;
					if (result_word.power_on !== want.power_on
							|| result_word.running !== want.running
							|| result_word.minutes !== want.minutes
							|| result_word.seconds !== want.seconds
							|| result_word.tone_select !== want.tone_select
							|| result_word.tone_start !== want.tone_start
							|| result_word.port_clear !== want.port_clear) begin
						if (mismatches < 10) begin
							$display("%0t: result %0d differs", $realtime, checked);
							$display("  expected pwr=%b run=%b %0d:%0d tone=%0d start=%b clr=%b",
								want.power_on, want.running, want.minutes, want.seconds,
								want.tone_select, want.tone_start, want.port_clear);
							$display("  got      pwr=%b run=%b %0d:%0d tone=%0d start=%b clr=%b",
								result_word.power_on, result_word.running,
								result_word.minutes, result_word.seconds,
								result_word.tone_select, result_word.tone_start,
								result_word.port_clear);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			waiting <= expected_words.size();
		end
	end

endmodule

// ----- sim/keypad_countdown_timer_control_tb.sv -----
// Testbench top for the keypad countdown timer control.
// Drives key and tick words, stalls the result side and reports the verdict.
// Depends on kctc_pkg, both channel interfaces, the block and kctc_timer_checker.
module keypad_countdown_timer_control_tb
	import kctc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 1100;
	localparam int QUIET_TAIL  = 150;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;

	kctc_item_if   item_ch();
	kctc_result_if result_ch();

	int mismatches;
	int waiting;
	int checked;
	int alarms;

	bit idle_on;
	bit powered;
	int words_sent;
	int sessions;
	int fills;
	int cycles = 0;

	keypad_countdown_timer_control DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	kctc_timer_checker timer_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_word    ({item_ch.kind, item_ch.key_code, item_ch.long_press}),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_word  ({result_ch.power_on, result_ch.running, result_ch.minutes,
			result_ch.seconds, result_ch.tone_select, result_ch.tone_start,
			result_ch.port_clear}),
		.mismatches   (mismatches),
		.waiting      (waiting),
		.checked      (checked),
		.alarms       (alarms)
	);

	always #4 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Send one word, with an occasional gap in front, and wait for it to be taken
	task automatic send_word(input logic kind, input logic [2:0] code, input logic lng);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= kind;
		item_ch.key_code   <= code;
		item_ch.long_press <= lng;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		words_sent++;
		if (kind == KIND_KEY && code == KEY_POWER)
			powered = !powered;
	endtask

	task automatic stray_word();
		send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
			1'($urandom_range(0, 1)));
	endtask

	// Hold off until every result has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	// One use of the appliance: power up, set a time, start, count down, finish
	task automatic run_session();
		int n;
		sessions++;
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) stray_word();
		if (!powered)
			send_word(KIND_KEY, KEY_POWER, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) == 0) begin
			// drive the time up to its ceiling and push against it
			fills++;
			repeat (35) send_word(KIND_KEY, KEY_MINUTES, 1'b1);
			repeat ($urandom_range(18, 24))
				send_word(KIND_KEY, KEY_SECONDS, 1'($urandom_range(0, 1)));
			send_word(KIND_KEY, KEY_MINUTES, 1'($urandom_range(0, 1)));
		end else begin
			// short times so that the countdown reaches zero
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0)
					send_word(KIND_KEY, KEY_MINUTES, 1'($urandom_range(0, 1)));
				else if ($urandom_range(0, 9) == 0)
					stray_word();
				else
					send_word(KIND_KEY, KEY_SECONDS, 1'($urandom_range(0, 1)));
			end
		end
		send_word(KIND_KEY, KEY_START, 1'($urandom_range(0, 1)));
		n = $urandom_range(0, 90);
		repeat (n) begin
			if ($urandom_range(0, 11) == 0)
				stray_word();
			else
				send_word(KIND_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		end
		case ($urandom_range(0, 3))
			0: send_word(KIND_KEY, KEY_START, 1'($urandom_range(0, 1)));
			1: send_word(KIND_KEY, KEY_POWER, 1'($urandom_range(0, 1)));
			default: ;
		endcase
	endtask

	// Result side: ready with random stall bursts
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 2);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		item_ch.valid      = 1'b0;
		item_ch.kind       = KIND_KEY;
		item_ch.key_code   = '0;
		item_ch.long_press = 1'b0;
		arst_n             = 1'b0;
		idle_on            = 1'b1;
		powered            = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// powered off: tick and setting keys do nothing
		send_word(KIND_TICK, 3'd7, 1'b1);
		send_word(KIND_KEY, KEY_MINUTES, 1'b0);
		send_word(KIND_KEY, KEY_SECONDS, 1'b1);
		send_word(KIND_KEY, KEY_START, 1'b0);
		// unused key codes
		send_word(KIND_KEY, 3'd0, 1'b0);
		send_word(KIND_KEY, 3'd5, 1'b0);
		send_word(KIND_KEY, 3'd6, 1'b1);
		send_word(KIND_KEY, 3'd7, 1'b0);
		// power on, start with no time set, tick while idle
		send_word(KIND_KEY, KEY_POWER, 1'b0);
		send_word(KIND_KEY, KEY_START, 1'b0);
		send_word(KIND_TICK, 3'd0, 1'b0);
		// set 04:04 and run
		send_word(KIND_KEY, KEY_SECONDS, 1'b1);
		send_word(KIND_KEY, KEY_SECONDS, 1'b0);
		send_word(KIND_KEY, KEY_MINUTES, 1'b0);
		send_word(KIND_KEY, KEY_MINUTES, 1'b1);
		send_word(KIND_KEY, KEY_START, 1'b1);
		// setting keys while running only click, then one tick
		send_word(KIND_KEY, KEY_MINUTES, 1'b0);
		send_word(KIND_KEY, KEY_SECONDS, 1'b1);
		send_word(KIND_TICK, KEY_SECONDS, 1'b1);
		// stop clears, then count one second down into the alarm and power off
		send_word(KIND_KEY, KEY_START, 1'b0);
		send_word(KIND_KEY, KEY_SECONDS, 1'b0);
		send_word(KIND_KEY, KEY_START, 1'b0);
		send_word(KIND_TICK, 3'd4, 1'b0);
		send_word(KIND_TICK, 3'd1, 1'b1);
		send_word(KIND_KEY, KEY_POWER, 1'b1);
		drain();

		// random sessions, no idling near the end
		while (words_sent < ITEMS) begin
			idle_on = (words_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			run_session();
			if (sessions % 5 == 0)
				drain();
		end
		idle_on = 1'b0;
		drain();
		repeat (6) @(posedge clk);

		$display("Sent %0d key and tick words over %0d sessions (%0d pushed to 99:59);",
			words_sent, sessions, fills);
		$display("checked %0d result words, %0d of them alarm tones.", checked, alarms);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- keypad_countdown_timer_control.f -----
rtl/core/kctc_pkg.sv
rtl/core/kctc_item_if.sv
rtl/core/kctc_result_if.sv
rtl/core/kctc_step.sv
rtl/core/keypad_countdown_timer_control.sv
sim/kctc_timer_checker.sv
sim/keypad_countdown_timer_control_tb.sv
